// ----- rtl/mbc_pkg.sv -----
package mbc_pkg;

  localparam int LETTERS = 5;
  localparam int POS_W   = 10;
  localparam int CODE_W  = 3;
  localparam int ASCII_W = 8;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_CALL = 1'b1;

  localparam logic [CODE_W-1:0] CODE_N = 3'd0;
  localparam logic [CODE_W-1:0] CODE_A = 3'd1;
  localparam logic [CODE_W-1:0] CODE_C = 3'd2;
  localparam logic [CODE_W-1:0] CODE_G = 3'd3;
  localparam logic [CODE_W-1:0] CODE_T = 3'd4;

  // result queue: three-entry circular buffer
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 2;

  typedef struct packed {
    logic              valid;
    logic              is_call;
    logic              in_range;
    logic              in_len;
    logic [CODE_W-1:0] letter;
  } s1_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [CODE_W-1:0]  code;
    logic [ASCII_W-1:0] ascii;
  } res_t;

  function automatic logic [CODE_W-1:0] letter_of(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      "a", "A": code = CODE_A;
      "c", "C": code = CODE_C;
      "g", "G": code = CODE_G;
      "t", "T": code = CODE_T;
      default:  code = CODE_N;
    endcase
    return code;
  endfunction

  function automatic logic [ASCII_W-1:0] ascii_of(input logic [CODE_W-1:0] code);
    logic [ASCII_W-1:0] ch;
    case (code)
      CODE_A:  ch = "a";
      CODE_C:  ch = "c";
      CODE_G:  ch = "g";
      CODE_T:  ch = "t";
      default: ch = "n";
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/mbc_ram.sv -----
module mbc_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when read and write hit the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mbc_vote.sv -----
module mbc_vote #(
  parameter int COUNT_BITS = 16
) (
  input  mbc_pkg::s1_ctl_t                          ctl,
  input  logic [mbc_pkg::POS_W-1:0]                 position,
  input  logic [mbc_pkg::LETTERS*COUNT_BITS-1:0]    row_cur,
  output logic                                      wr_en,
  output logic [mbc_pkg::LETTERS*COUNT_BITS-1:0]    row_nxt,
  output logic                                      res_push,
  output mbc_pkg::res_t                             res
);
  import mbc_pkg::*;

  logic [COUNT_BITS-1:0] cnt [LETTERS];
  logic [COUNT_BITS-1:0] best;
  logic [CODE_W-1:0]     win;
  logic [CODE_W-1:0]     code;

  always_comb begin
    for (int j = 0; j < LETTERS; j++) begin
      cnt[j] = row_cur[j*COUNT_BITS +: COUNT_BITS];
    end

    // scan n,a,c,g,t; strict compare keeps the earlier letter on a tie
    best = '0;
    win  = CODE_N;
    for (int j = 0; j < LETTERS; j++) begin
      if (cnt[j] > best) begin
        best = cnt[j];
        win  = CODE_W'(j);
      end
    end

    // saturating vote for the base's letter; a call clears the row instead
    row_nxt = row_cur;
    for (int j = 0; j < LETTERS; j++) begin
      if (CODE_W'(j) == ctl.letter && cnt[j] != '1) begin
        row_nxt[j*COUNT_BITS +: COUNT_BITS] = cnt[j] + 1'b1;
      end
    end
    if (ctl.is_call) begin
      row_nxt = '0;
    end

    wr_en = ctl.valid && ctl.in_range && (ctl.is_call || ctl.in_len);

    code         = ctl.in_range ? win : CODE_N;
    res.position = position;
    res.code     = code;
    res.ascii    = ascii_of(code);
    res_push     = ctl.valid && ctl.is_call;
  end

endmodule

// ----- rtl/mbc_outq.sv -----
module mbc_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbc_pkg::res_t push_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mbc_pkg::res_t out_data,
  output logic [mbc_pkg::OUTQ_CNT_W-1:0] count
);
  import mbc_pkg::*;

  res_t                  q_r [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] rd_ptr_r;
  logic [OUTQ_PTR_W-1:0] wr_ptr_r;
  logic [OUTQ_CNT_W-1:0] count_r;
  logic                  pop;

  assign out_valid = (count_r != '0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign count     = count_r;

  function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
    return (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == OUTQ_CNT_W'(OUTQ_DEPTH)))
    else $error("result queue overflow");

endmodule

// ----- rtl/majority_base_consensus_unit.sv -----
// Channel  Ports                                   Direction  Transfer when
// -------  --------------------------------------  ---------  -------------------------
// in       in_kind, in_position, in_base_char      sink       in_valid && in_ready
// out      out_position_res, out_base_code,        source     out_valid && out_ready
//          out_base_ascii
// cfg      cfg_wr_data (seq_length)                sink       cfg_wr_en
//
// One item per cycle: the input register issues the row read, the next cycle
// does the vote or call on the registered read data and writes the row back.
// A write-back register forwards the row written at the same edge as a read.
// A call result passes the input register and the result queue before it
// raises out_valid. After reset a clearing pass zeroes the row memory with
// in_ready low; cfg writes are taken throughout.
// Outside the clearing pass, in_ready drops only when the result queue (three
// entries) plus a call in flight would leave no room.
module majority_base_consensus_unit #(
  parameter int MAX_COLUMNS = 1024,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [mbc_pkg::POS_W-1:0]     in_position,
  input  logic [mbc_pkg::CHAR_W-1:0]    in_base_char,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mbc_pkg::POS_W-1:0]     out_position_res,
  output logic [mbc_pkg::CODE_W-1:0]    out_base_code,
  output logic [mbc_pkg::ASCII_W-1:0]   out_base_ascii,
  input  logic                          cfg_wr_en,
  input  logic [mbc_pkg::LEN_W-1:0]     cfg_wr_data
);
  import mbc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = LETTERS * COUNT_BITS;

  // configuration
  logic [LEN_W-1:0] seq_len_r;

  // clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // input decode
  logic                     in_fire;
  logic [ADDR_W+POS_W-1:0]  pos_ext;
  logic [ADDR_W-1:0]        in_addr;
  s1_ctl_t                  in_ctl;

  // vote stage
  s1_ctl_t           s1_ctl_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic [ROW_W-1:0]  ram_rdata;
  logic [ROW_W-1:0]  row_cur;
  logic              vote_we;
  logic [ROW_W-1:0]  vote_row;
  logic              res_push;
  res_t              res;

  // row memory write port and forwarding
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              fwd_valid_r;
  logic [ADDR_W-1:0] fwd_addr_r;
  logic [ROW_W-1:0]  fwd_data_r;

  // result queue
  res_t                  q_head;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic                  s1_call;

  // hold a slot for every call that has not reached the queue yet
  assign s1_call  = s1_ctl_r.valid && s1_ctl_r.is_call;
  assign in_ready = !clearing_r &&
    (({1'b0, q_count} + (OUTQ_CNT_W+1)'(s1_call)) <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH - 1));
  assign in_fire  = in_valid && in_ready;

  assign pos_ext = (ADDR_W+POS_W)'(in_position);
  assign in_addr = pos_ext[ADDR_W-1:0];

  always_comb begin
    in_ctl.valid    = in_fire;
    in_ctl.is_call  = (in_kind == KIND_CALL);
    in_ctl.in_range = (32'(in_position) < MAX_COLUMNS);
    in_ctl.in_len   = ({1'b0, in_position} < seq_len_r);
    in_ctl.letter   = letter_of(in_base_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      seq_len_r <= cfg_wr_data;
    end
  end

  // sweep every row to zero, then open the input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(MAX_COLUMNS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // advance the input register; the row read is issued at the same edge
  always_ff @(posedge clk) begin
    s1_addr_r <= in_addr;
    s1_pos_r  <= in_position;
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= in_ctl;
    end
  end

  assign ram_we    = clearing_r || vote_we;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clearing_r ? '0 : vote_row;

  mbc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_COLUMNS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // the read at the write-back edge sees the old row; take the written one
  always_ff @(posedge clk) begin
    fwd_addr_r <= ram_waddr;
    fwd_data_r <= ram_wdata;
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= ram_we;
    end
  end

  assign row_cur = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : ram_rdata;

  mbc_vote #(
    .COUNT_BITS (COUNT_BITS)
  ) u_vote (
    .ctl      (s1_ctl_r),
    .position (s1_pos_r),
    .row_cur  (row_cur),
    .wr_en    (vote_we),
    .row_nxt  (vote_row),
    .res_push (res_push),
    .res      (res)
  );

  mbc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_head),
    .count     (q_count)
  );

  assign out_position_res = q_head.position;
  assign out_base_code    = q_head.code;
  assign out_base_ascii   = q_head.ascii;

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_ctl_r.valid && !out_valid))
    else $error("item in flight during clearing pass");

  a_forward_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.valid && $past(ram_we) && $past(ram_waddr) == s1_addr_r)
      |-> (row_cur == $past(ram_wdata)))
    else $error("stale row used after same-address write");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    (({1'b0, q_count} + (OUTQ_CNT_W+1)'(s1_call)) <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH)))
    else $error("calls in flight exceed result queue");

endmodule

// ----- tb/tb.sv -----
module tb;
  import mbc_pkg::*;

  localparam int MAX_COLS  = 1024;
  localparam int VOTE_BITS = 16;
  // cycles with no transfer on either channel before the run is called hung;
  // covers the post-reset clearing pass plus the longest idle stretches
  localparam int HANG_LIMIT = 4000;
  // adds produce no result, so let the pipeline drain before touching cfg
  localparam int DRAIN_CYCLES = 8;

  // Vote tally and pending call results, kept in step with the accepted
  // input stream. Each call result is checked against the oldest due entry.
  class consensus_scoreboard;
    bit [VOTE_BITS-1:0] votes [LETTERS][MAX_COLS];
    bit [LEN_W-1:0]     seq_len;
    res_t               calls_due[$];
    int                 errors;
    bit [ASCII_W-1:0]   glyph [LETTERS];

    function new();
      seq_len = LEN_RESET;
      errors  = 0;
      glyph   = '{"n", "a", "c", "g", "t"};
    endfunction

    // fold to lower case; only 'A' and 'a' land on 'a', and so on
    function logic [CODE_W-1:0] vote_letter(logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] folded;
      folded = ch | 8'h20;
      if (folded == "a") return CODE_A;
      if (folded == "c") return CODE_C;
      if (folded == "g") return CODE_G;
      if (folded == "t") return CODE_T;
      return CODE_N;
    endfunction

    function int pending();
      return calls_due.size();
    endfunction

    function void note_item(logic kind, logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
      logic [CODE_W-1:0]    code;
      logic [VOTE_BITS-1:0] best;
      res_t                 due;
      if (kind == KIND_ADD) begin
        if ({1'b0, pos} < seq_len) begin
          code = vote_letter(ch);
          if (votes[code][pos] != '1) votes[code][pos] += 1'b1;
        end
        return;
      end
      // strict greater-than scan in n, a, c, g, t order; clear as we go
      best = '0;
      code = CODE_N;
      for (int j = CODE_N; j <= CODE_T; j++) begin
        if (votes[j][pos] > best) begin
          best = votes[j][pos];
          code = CODE_W'(j);
        end
        votes[j][pos] = '0;
      end
      due.position = pos;
      due.code     = code;
      due.ascii    = glyph[code];
      calls_due.push_back(due);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (calls_due.size() == 0) begin
        $error("unexpected result for column %0d", got.position);
        errors++;
        return;
      end
      want = calls_due.pop_front();
      if (got.position !== want.position) begin
        $error("position_res: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.code !== want.code) begin
        $error("base_code: expected %0d, got %0d", want.code, got.code);
        errors++;
      end
      if (got.ascii !== want.ascii) begin
        $error("base_ascii: expected %0h, got %0h", want.ascii, got.ascii);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_kind = KIND_ADD;
  logic [POS_W-1:0]   in_position = '0;
  logic [CHAR_W-1:0]  in_base_char = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [POS_W-1:0]   out_position_res;
  logic [CODE_W-1:0]  out_base_code;
  logic [ASCII_W-1:0] out_base_ascii;
  logic               cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]   cfg_wr_data = '0;

  consensus_scoreboard sb = new();

  // when set, the matching side runs back to back with no idle cycles
  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  int quiet_cycles = 0;

  majority_base_consensus_unit #(
    .MAX_COLUMNS (MAX_COLS),
    .COUNT_BITS  (VOTE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_position      (in_position),
    .in_base_char     (in_base_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position_res (out_position_res),
    .out_base_code    (out_base_code),
    .out_base_ascii   (out_base_ascii),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hang detector: count cycles with no transfer on either channel. Starts
  // after reset, so the clearing pass is covered by the limit itself.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
        $display("FAIL majority_base_consensus_unit");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one item and hold it until the transfer. Valid is only dropped
  // when an idle gap is drawn, so back-to-back items keep it high.
  task automatic drive_item(logic kind, logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_position  <= pos;
    in_base_char <= ch;
    do @(posedge clk); while (!in_ready);
    sb.note_item(kind, pos, ch);
  endtask

  // Quiesce the input, wait for every call result, let trailing adds drain,
  // then write the column count.
  task automatic write_length(logic [LEN_W-1:0] len);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    sb.seq_len = len;
  endtask

  // Random traffic under one column count. Most items hit a hot window of
  // eight columns so votes pile up and calls see real contests and ties;
  // for lengths 9 to 1023 it straddles the length boundary half the time.
  task automatic random_phase(int unsigned len, int unsigned count);
    int unsigned       span;
    int unsigned       hot_base;
    logic              kind;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    bit [CHAR_W-1:0]   bases [8];
    bases = '{"A", "C", "G", "T", "a", "c", "g", "t"};
    write_length(LEN_W'(len));
    span = (len == 0) ? 1 : ((len > MAX_COLS) ? MAX_COLS : len);
    if (span <= 8)
      hot_base = 0;
    else if ($urandom_range(0, 1))
      hot_base = (span - 4 > MAX_COLS - 8) ? MAX_COLS - 8 : span - 4;
    else
      hot_base = $urandom_range(0, span - 8);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
      kind = ($urandom_range(0, 99) < 15) ? KIND_CALL : KIND_ADD;
      if ($urandom_range(0, 99) < 75)
        pos = POS_W'(hot_base + $urandom_range(0, 7));
      else
        pos = POS_W'($urandom_range(0, MAX_COLS - 1));
      if ($urandom_range(0, 99) < 65)
        ch = bases[$urandom_range(0, 7)];
      else
        ch = CHAR_W'($urandom_range(0, 255));
      drive_item(kind, pos, ch);
    end
  endtask

  // Result side: draw a stall per result, then hold ready until a transfer.
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{out_position_res, out_base_code, out_base_ascii});
      taken++;
      if (taken % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at the reset length: every letter in both cases, other
    // bytes as n, empty column, tie, clear after call, base_char on a call.
    drive_item(KIND_ADD, 10'd1023, "A");
    drive_item(KIND_ADD, 10'd1023, "a");
    drive_item(KIND_ADD, 10'd1023, "C");
    drive_item(KIND_ADD, 10'd5, "c");
    drive_item(KIND_ADD, 10'd5, "G");
    drive_item(KIND_ADD, 10'd7, "N");
    drive_item(KIND_ADD, 10'd7, 8'h00);
    drive_item(KIND_ADD, 10'd7, 8'hFF);
    drive_item(KIND_ADD, 10'd7, "t");
    drive_item(KIND_ADD, 10'd900, "t");
    drive_item(KIND_ADD, 10'd2, "g");
    drive_item(KIND_ADD, 10'd2, "T");
    drive_item(KIND_ADD, 10'd2, "t");
    drive_item(KIND_CALL, 10'd0, "T");
    drive_item(KIND_CALL, 10'd1023, 8'hFF);
    drive_item(KIND_CALL, 10'd1023, 8'h00);
    drive_item(KIND_CALL, 10'd5, "a");
    drive_item(KIND_CALL, 10'd7, "c");
    drive_item(KIND_CALL, 10'd2, "g");

    // Short length: adds past the end drop, calls past the end still
    // report what was stored before the length came down.
    write_length(11'd4);
    drive_item(KIND_ADD, 10'd4, "a");
    drive_item(KIND_ADD, 10'd3, "a");
    drive_item(KIND_ADD, 10'd1023, "c");
    drive_item(KIND_CALL, 10'd4, 8'h00);
    drive_item(KIND_CALL, 10'd3, 8'h00);
    drive_item(KIND_CALL, 10'd900, 8'h00);

    // Smallest legal length, then zero, where every add drops.
    write_length(11'd1);
    drive_item(KIND_ADD, 10'd0, "g");
    drive_item(KIND_ADD, 10'd1, "g");
    drive_item(KIND_CALL, 10'd0, 8'h00);
    drive_item(KIND_CALL, 10'd1, 8'h00);
    write_length(11'd0);
    drive_item(KIND_ADD, 10'd0, "c");
    drive_item(KIND_CALL, 10'd0, 8'h00);

    random_phase(1024, 250);
    random_phase(1, 200);
    random_phase($urandom_range(2, 1023), 250);
    random_phase(2047, 250);
    random_phase(0, 30);
    random_phase($urandom_range(1, 1024), 250);
    random_phase(1024, 300);

    // Drain: wait for every call result, then watch for strays.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS majority_base_consensus_unit");
    else
      $display("FAIL majority_base_consensus_unit");
    $finish;
  end

endmodule
